// ===== hdl/lisl_pkg.sv =====
// ----------------------------------------------------------------------------
// lisl_pkg
// Shared helpers for the longest increasing subsequence length block.
// ----------------------------------------------------------------------------
package lisl_pkg;

  // Bits needed to hold a length from 0 up to and including max_len.
  function automatic int len_bits(input int max_len);
    len_bits = $clog2(max_len + 1);
  endfunction

endpackage

// ===== hdl/longest_increasing_subsequence_length_top.sv =====
// An item that starts the store, lands at or above its top, or replaces a lone entry is handled
// in the idle state; any smaller item runs a binary search over the tail memory,
// one registered memory read per step. An item flagged last then passes through the emit
// state to load the result, and waits there while an earlier result still waits on out_ready.
// The block takes no new item until the search, and any emit, of the last one is done.
// Reset (rst, synchronous) clears the length, overflow flag and handshake state.
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length_top
// Patience sorting over a tail memory: tracks the length of the longest
// strictly increasing subsequence and reports it on the final element.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length_top
  import lisl_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [VALUE_BITS-1:0]          value,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [len_bits(MAX_LEN)-1:0]   seq_length,
  output logic                           overflow
);

  localparam int LEN_W = len_bits(MAX_LEN);
  localparam int IDX_W = $clog2(MAX_LEN);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EMIT} state_t;

  state_t                state;
  logic [LEN_W-1:0]      run_length;
  logic                  overflow_seen;
  logic [VALUE_BITS-1:0] top_value;
  logic [VALUE_BITS-1:0] cur_value;
  logic                  cur_last;
  logic [IDX_W-1:0]      lo;
  logic [IDX_W-1:0]      hi;
  logic [IDX_W-1:0]      mid;
  logic                  eq_seen;

  logic [VALUE_BITS-1:0] tail_mem [MAX_LEN];
  logic [VALUE_BITS-1:0] rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic                  accept;
  logic                  store_full;
  logic                  need_search;
  logic [IDX_W-1:0]      len_m1;
  logic                  probe_gt;
  logic [IDX_W-1:0]      lo_next;
  logic [IDX_W-1:0]      hi_next;
  logic [IDX_W-1:0]      mid_next;
  logic                  eq_next;
  logic                  search_done;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign store_full  = (run_length == LEN_W'(MAX_LEN));
  assign need_search = (run_length > LEN_W'(1)) && (value < top_value);
  assign len_m1      = IDX_W'(run_length - LEN_W'(1));

  // One search step: narrow [lo, hi] around the first entry above the value.
  always_comb begin
    probe_gt    = (rd_data > cur_value);
    lo_next     = probe_gt ? lo : IDX_W'(mid + IDX_W'(1));
    hi_next     = probe_gt ? mid : hi;
    eq_next     = eq_seen || (rd_data == cur_value);
    mid_next    = IDX_W'(lo_next + ((hi_next - lo_next) >> 1));
    search_done = (lo_next == hi_next);
    rd_addr     = (state == S_IDLE) ? IDX_W'(len_m1 >> 1) : mid_next;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = value;
    if (accept) begin
      if (run_length == '0) begin
        wr_en = 1'b1;
      end else if (value > top_value) begin
        wr_en   = !store_full;
        wr_addr = IDX_W'(run_length);
      end else if (value < top_value && run_length == LEN_W'(1)) begin
        wr_en = 1'b1;
      end
    end else if (state == S_SEARCH && search_done && !eq_next) begin
      wr_en   = 1'b1;
      wr_addr = lo_next;
      wr_data = cur_value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tail_mem[wr_addr] <= wr_data;
    end
    rd_data <= tail_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      run_length    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          lo      <= '0;
          hi      <= len_m1;
          mid     <= IDX_W'(len_m1 >> 1);
          eq_seen <= 1'b0;
          if (accept) begin
            cur_value <= value;
            cur_last  <= last;
            if (need_search) begin
              state <= S_SEARCH;
            end else if (last) begin
              state <= S_EMIT;
            end
            if (run_length == '0) begin
              top_value  <= value;
              run_length <= LEN_W'(1);
            end else if (value > top_value) begin
              if (store_full) begin
                overflow_seen <= 1'b1;
              end else begin
                top_value  <= value;
                run_length <= LEN_W'(run_length + LEN_W'(1));
              end
            end else if (value < top_value) begin
              if (run_length == LEN_W'(1)) begin
                top_value <= value;
              end
            end
          end
        end
        S_SEARCH: begin
          lo      <= lo_next;
          hi      <= hi_next;
          mid     <= mid_next;
          eq_seen <= eq_next;
          if (search_done) begin
            // Replacing the top entry moves the cached top as well.
            if (!eq_next && lo_next == len_m1) begin
              top_value <= cur_value;
            end
            state <= cur_last ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          // Hold until the output register is free, then restart the sequence.
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            seq_length    <= run_length;
            overflow      <= overflow_seen;
            run_length    <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lisl_checker.sv =====
// ----------------------------------------------------------------------------
// lisl_checker
// Port-level checks on the longest increasing subsequence length block.
// ----------------------------------------------------------------------------
module lisl_checker
  import lisl_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [VALUE_BITS-1:0]        value,
  input logic                         last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [len_bits(MAX_LEN)-1:0] seq_length,
  input logic                         overflow
);

  localparam int LEN_W = len_bits(MAX_LEN);

  // A waiting request must hold its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(value) && $stable(last))
    else $error("request changed while waiting");

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seq_length) && $stable(overflow))
    else $error("result changed while stalled");

  // Every sequence has at least one element.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seq_length != '0)
    else $error("zero length reported");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seq_length <= LEN_W'(MAX_LEN))
    else $error("length above store depth");

  // Overflow only happens once the store is full, and the length saturates there.
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> seq_length == LEN_W'(MAX_LEN))
    else $error("overflow without saturated length");

endmodule

bind longest_increasing_subsequence_length_top lisl_checker #(
  .MAX_LEN    (MAX_LEN),
  .VALUE_BITS (VALUE_BITS)
) u_lisl_checker (.*);

// ===== tb/sv/lis_length_checker.sv =====
// ----------------------------------------------------------------------------
// lis_length_checker
// Watches both channels of the subsequence length block, tracks the tail
// store from every accepted request and checks each reported length and
// overflow flag against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lis_length_checker
  import lisl_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [VALUE_BITS-1:0]          value,
  input  logic                           last,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [len_bits(MAX_LEN)-1:0]   seq_length,
  input  logic                           overflow,
  output int                             errors,
  output int                             waiting
);

  localparam int LEN_W = len_bits(MAX_LEN);

  typedef struct packed {
    logic [LEN_W-1:0] seq_length;
    logic             overflow;
  } lis_result_t;

  logic [VALUE_BITS-1:0] tails [0:MAX_LEN-1];
  int                    tail_count = 0;
  bit                    store_clipped = 1'b0;
  lis_result_t           expected_lengths [$];
  int                    fail_count = 0;
  int                    pending_count = 0;

  assign errors  = fail_count;
  assign waiting = pending_count;

  // Patience step: append above the top, ignore a duplicate, else replace the
  // smallest tail greater than the value.
  function automatic void absorb_value(input logic [VALUE_BITS-1:0] v);
    int lo;
    int hi;
    int mid;
    if (tail_count == 0) begin
      tails[0]   = v;
      tail_count = 1;
      return;
    end
    if (v > tails[tail_count-1]) begin
      if (tail_count < MAX_LEN) begin
        tails[tail_count] = v;
        tail_count++;
      end else begin
        store_clipped = 1'b1;
      end
      return;
    end
    lo = 0;
    hi = tail_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (tails[mid] > v) hi = mid;
      else lo = mid + 1;
    end
    if (lo > 0 && tails[lo-1] == v) return;
    if (lo < tail_count) tails[lo] = v;
  endfunction

  always @(posedge clk) begin
    lis_result_t got;
    lis_result_t want;
    lis_result_t pred;
    if (rst) begin
      tail_count    = 0;
      store_clipped = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{seq_length, overflow};
        if (expected_lengths.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, seq_length %0d overflow %0b",
                   $time, got.seq_length, got.overflow);
        end else begin
          want = expected_lengths.pop_front();
          if (got.seq_length !== want.seq_length) begin
            fail_count++;
            $display("%0t: seq_length expected %0d, got %0d",
                     $time, want.seq_length, got.seq_length);
          end
          if (got.overflow !== want.overflow) begin
            fail_count++;
            $display("%0t: overflow expected %0b, got %0b",
                     $time, want.overflow, got.overflow);
          end
        end
      end
      if (in_valid && in_ready) begin
        absorb_value(value);
        if (last) begin
          pred             = '{LEN_W'(tail_count), store_clipped};
          expected_lengths = {expected_lengths, pred};
          tail_count       = 0;
          store_clipped    = 1'b0;
        end
      end
    end
    pending_count = expected_lengths.size();
  end

endmodule

// ===== tb/sv/longest_increasing_subsequence_length_top_tb.sv =====
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length_top_tb
// Drives value sequences into the subsequence length block: a directed part
// covering single elements, duplicates, replacements and a full tail store,
// then random sequences of mixed shape, with random stalls on both sides.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length_top_tb;
  import lisl_pkg::*;

  localparam int MAX_LEN       = 1024;
  localparam int VALUE_BITS    = 16;
  localparam int LEN_W         = len_bits(MAX_LEN);
  localparam int RANDOM_ITEMS  = 800;
  localparam int CALM_TAIL     = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 30;

  typedef enum int {SPREAD, NARROW, RISING, FALLING, CROWDED_TOP} value_style_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic [VALUE_BITS-1:0] value     = '0;
  logic                  last      = 1'b0;
  logic                  out_ready = 1'b1;
  logic                  in_ready;
  logic                  out_valid;
  logic [LEN_W-1:0]      seq_length;
  logic                  overflow;

  int          fail_count;
  int          waiting;
  bit          calm       = 1'b0;
  bit          idle_on    = 1'b1;
  int          stall_left = 0;
  int          sent       = 0;
  int unsigned cycles     = 0;

  logic [VALUE_BITS-1:0] run_buf [$];

  longest_increasing_subsequence_length_top #(
    .MAX_LEN(MAX_LEN),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .value(value), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .seq_length(seq_length), .overflow(overflow)
  );

  lis_length_checker #(
    .MAX_LEN(MAX_LEN),
    .VALUE_BITS(VALUE_BITS)
  ) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .value(value), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .seq_length(seq_length), .overflow(overflow),
    .errors(fail_count), .waiting(waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver side: hold off results in bursts of random length.
  always @(negedge clk) begin
    if (rst || calm || !idle_on) begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_value(input logic [VALUE_BITS-1:0] v, input logic fin);
    int gap;
    if (!calm && idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= fin;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // Send the buffered sequence, flagging its final element.
  task automatic flush_run();
    for (int i = 0; i < run_buf.size(); i++)
      push_value(run_buf[i], i == run_buf.size() - 1);
    run_buf.delete();
  endtask

  task automatic wait_drained();
    while (waiting != 0) @(negedge clk);
  endtask

  initial begin
    int           random_start;
    int           run_len;
    int           walk;
    value_style_t style;
    logic [VALUE_BITS-1:0] v;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-element sequences at both extremes.
    run_buf = {16'h0000};
    flush_run();
    run_buf = {16'hFFFF};
    flush_run();
    // Append, duplicate, replacement at the bottom and in the middle.
    run_buf = {16'd5, 16'd10, 16'd10, 16'd3, 16'hFFFF, 16'd0, 16'd7};
    flush_run();
    run_buf = {16'd9, 16'd8, 16'd7, 16'd6};
    flush_run();
    run_buf = {16'd4, 16'd4, 16'd4};
    flush_run();
    // Fill the store, replace inside it, then append past its depth.
    for (int i = 0; i < MAX_LEN; i++) run_buf = {run_buf, VALUE_BITS'(i * 60)};
    run_buf = {run_buf, 16'd30, 16'hFFFF, VALUE_BITS'((MAX_LEN - 1) * 60)};
    flush_run();
    run_buf = {16'd2, 16'd1};
    flush_run();

    in_valid <= 1'b0;
    wait_drained();

    random_start = sent;
    while (sent - random_start < RANDOM_ITEMS) begin
      calm    = (sent - random_start >= RANDOM_ITEMS - CALM_TAIL);
      idle_on = ($urandom_range(0, 3) != 0);
      run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 300)
                                             : $urandom_range(1, 24);
      style   = value_style_t'($urandom_range(0, 4));
      walk    = $urandom_range(0, 65535);
      for (int i = 0; i < run_len; i++) begin
        case (style)
          SPREAD: v = VALUE_BITS'($urandom_range(0, 65535));
          NARROW: v = VALUE_BITS'($urandom_range(0, 15));
          RISING: begin
            walk = walk + int'($urandom_range(0, 300)) - 40;
            v    = walk[VALUE_BITS-1:0];
          end
          FALLING: begin
            walk = walk - int'($urandom_range(0, 300)) + 40;
            v    = walk[VALUE_BITS-1:0];
          end
          default: v = 16'hFFFF - VALUE_BITS'($urandom_range(0, 20));
        endcase
        run_buf = {run_buf, v};
      end
      flush_run();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
